[src/huffman_stream_decoder_top_assert.svh]
// assertion macros for the huffman stream decoder checker
// no dependencies
`ifndef HUFFMAN_STREAM_DECODER_TOP_ASSERT_SVH
`define HUFFMAN_STREAM_DECODER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HSD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsd check failed");

// antecedent implies consequent in the next cycle
`define HSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsd check failed");

`endif

[src/hsd_pkg.sv]
// types and constants shared by the huffman stream decoder modules
// no dependencies
package hsd_pkg;
   localparam int MAX_SYMBOLS_DEF = 256;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int NODE_DEPTH      = 512;
   localparam int NODE_AW         = 9;
   localparam int NODE_W          = 19;
   localparam int LEAF_BIT        = 18;
   localparam int STACK_DEPTH     = 256;
   localparam int STACK_AW        = 8;
   localparam int HDR_W           = 6;

   typedef enum logic [2:0] {
      PH_MARK, PH_COUNT, PH_LEAVES, PH_TREE, PH_WALK, PH_DONE, PH_BAD
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_BIT, ST_JOIN_WAIT, ST_WALK_WAIT, ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_STEP, CMD_JOIN_RD, CMD_JOIN_DO, CMD_WALK_RD,
      CMD_WALK_DO, CMD_FLUSH
   } cmd_type;

   typedef enum logic [1:0] {
      K_SIMPLE, K_JOIN, K_WALK
   } kind_type;

   typedef struct packed {
      logic     bits_done;
      kind_type kind;
      logic     can_emit;
      logic     pend_valid;
      logic     out_free;
   } dp_status_type;
endpackage

[src/hsd_if.sv]
// request and response channel interfaces of the huffman stream decoder
// no dependencies
interface hsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   modport source (output valid, output data_byte, output first_byte, input ready);
   modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       message_end;
   logic       malformed;
   logic       run_end;
   modport source (output valid, output symbol, output message_end, output malformed,
                   output run_end, input ready);
   modport sink (input valid, input symbol, input message_end, input malformed,
                 input run_end, output ready);
endinterface

[src/hsd_ram.sv]
// generic single write port ram with registered read
// no dependencies
module hsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[src/hsd_ctrl.sv]
// sequencer for the huffman stream decoder: walks the bits of each request
// depends on hsd_pkg
module hsd_ctrl
   import hsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output cmd_type       cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (status.bits_done) begin
               state_in = ST_FLUSH;
            end else begin
               unique case (status.kind)
                  K_JOIN: begin
                     cmd      = CMD_JOIN_RD;
                     state_in = ST_JOIN_WAIT;
                  end
                  K_WALK: begin
                     cmd      = CMD_WALK_RD;
                     state_in = ST_WALK_WAIT;
                  end
                  default: begin
                     if (status.can_emit) begin
                        cmd = CMD_STEP;
                     end
                  end
               endcase
            end
         end
         ST_JOIN_WAIT: begin
            if (status.can_emit) begin
               cmd      = CMD_JOIN_DO;
               state_in = ST_BIT;
            end
         end
         ST_WALK_WAIT: begin
            if (status.can_emit) begin
               cmd      = CMD_WALK_DO;
               state_in = ST_BIT;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd      = CMD_FLUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[src/hsd_datapath.sv]
// decoder state, tree build and tree walk datapath with node and stack memories
// depends on hsd_pkg, hsd_ram, hsd_if
module hsd_datapath
   import hsd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    req_data_byte,
   input  logic          req_first_byte,
   input  cmd_type       cmd,
   output dp_status_type status,
   hsd_rsp_if.source     rsp_chan
);
   localparam logic [HDR_W-1:0] CNT_LAST = HDR_W'(COUNT_BITS);
   localparam logic [8:0]       MAX_LV   = 9'(MAX_SYMBOLS);

   logic [7:0]            byte_ff, byte_in;
   logic [3:0]            bit_cnt_ff, bit_cnt_in;
   phase_type             phase_ff, phase_in;
   logic [HDR_W-1:0]      hdr_ff, hdr_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [8:0]            decl_ff, decl_in;
   logic [8:0]            found_ff, found_in;
   logic [7:0]            lshift_ff, lshift_in;
   logic [3:0]            lbc_ff, lbc_in;
   logic [8:0]            free_ff, free_in;
   logic [8:0]            depth_ff, depth_in;
   logic [8:0]            top_ff, top_in;
   logic [NODE_W-1:0]     root_ff, root_in;
   logic [NODE_W-1:0]     cur_ff, cur_in;
   logic                  pend_v_ff, pend_v_in;
   logic [7:0]            pend_sym_ff, pend_sym_in;
   logic                  pend_end_ff, pend_end_in;
   logic                  pend_bad_ff, pend_bad_in;
   logic                  out_v_ff, out_v_in;
   logic [7:0]            out_sym_ff, out_sym_in;
   logic                  out_end_ff, out_end_in;
   logic                  out_bad_ff, out_bad_in;
   logic                  out_run_ff, out_run_in;

   logic                  b;
   logic                  emit_v;
   logic [7:0]            emit_sym;
   logic                  emit_end;
   logic                  emit_bad;
   logic                  node_we;
   logic [NODE_W-1:0]     node_wdata;
   logic [NODE_W-1:0]     node_rdata;
   logic [NODE_AW-1:0]    node_raddr;
   logic                  stk_we;
   logic [8:0]            depth_m1;
   logic [8:0]            depth_m2;
   logic [8:0]            stk_rdata;
   logic [COUNT_BITS-1:0] left_dec;
   logic [7:0]            lv_byte;
   logic                  out_free;

   assign b        = byte_ff[7];
   assign depth_m1 = depth_ff - 9'd1;
   assign depth_m2 = depth_ff - 9'd2;
   assign left_dec = left_ff - COUNT_BITS'(1);
   assign lv_byte  = {decl_ff[6:0], b};
   assign out_free = !out_v_ff || rsp_chan.ready;
   assign node_raddr = b ? cur_ff[8:0] : cur_ff[17:9];

   hsd_ram #(.WIDTH(NODE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (free_ff),
      .wdata (node_wdata),
      .raddr (node_raddr),
      .rdata (node_rdata)
   );

   hsd_ram #(.WIDTH(9), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (depth_m1[STACK_AW-1:0]),
      .wdata (top_ff),
      .raddr (depth_m2[STACK_AW-1:0]),
      .rdata (stk_rdata)
   );

   always_comb begin
      status.bits_done  = (bit_cnt_ff == 4'd8);
      status.pend_valid = pend_v_ff;
      status.out_free   = out_free;
      status.can_emit   = !pend_v_ff || out_free;
      if (phase_ff == PH_WALK) begin
         status.kind = K_WALK;
      end else if (phase_ff == PH_TREE && lbc_ff == 4'd0 && !b && depth_ff >= 9'd2) begin
         status.kind = K_JOIN;
      end else begin
         status.kind = K_SIMPLE;
      end
   end

   always_comb begin
      byte_in    = byte_ff;
      bit_cnt_in = bit_cnt_ff;
      phase_in   = phase_ff;
      hdr_in     = hdr_ff;
      left_in    = left_ff;
      decl_in    = decl_ff;
      found_in   = found_ff;
      lshift_in  = lshift_ff;
      lbc_in     = lbc_ff;
      free_in    = free_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      root_in    = root_ff;
      cur_in     = cur_ff;
      emit_v     = 1'b0;
      emit_sym   = 8'd0;
      emit_end   = 1'b0;
      emit_bad   = 1'b0;
      node_we    = 1'b0;
      node_wdata = {1'b1, 10'd0, lshift_ff[6:0], b};
      stk_we     = 1'b0;

      unique case (cmd)
         CMD_LOAD: begin
            byte_in    = req_data_byte;
            bit_cnt_in = 4'd0;
            if (req_first_byte) begin
               phase_in = PH_MARK;
               hdr_in   = '0;
               left_in  = '0;
               decl_in  = '0;
               found_in = '0;
               lshift_in = '0;
               lbc_in   = '0;
               free_in  = '0;
               depth_in = '0;
            end
         end
         CMD_STEP: begin
            byte_in    = {byte_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 4'd1;
            unique case (phase_ff)
               PH_MARK: begin
                  phase_in = PH_COUNT;
                  hdr_in   = '0;
               end
               PH_COUNT: begin
                  left_in = {left_ff[COUNT_BITS-2:0], b};
                  hdr_in  = hdr_ff + HDR_W'(1);
                  if (hdr_ff + HDR_W'(1) >= CNT_LAST) begin
                     hdr_in  = '0;
                     decl_in = '0;
                     phase_in = ({left_ff[COUNT_BITS-2:0], b} == '0) ? PH_DONE : PH_LEAVES;
                  end
               end
               PH_LEAVES: begin
                  decl_in = {1'b0, lv_byte};
                  hdr_in  = hdr_ff + HDR_W'(1);
                  if (hdr_ff + HDR_W'(1) >= HDR_W'(8)) begin
                     hdr_in = '0;
                     // a zero leaf count stands for 256
                     if (lv_byte == 8'd0) begin
                        decl_in = 9'd256;
                     end
                     if ((lv_byte == 8'd0 ? 9'd256 : {1'b0, lv_byte}) > MAX_LV) begin
                        emit_v   = 1'b1;
                        emit_bad = 1'b1;
                     end else begin
                        phase_in = PH_TREE;
                     end
                  end
               end
               PH_TREE: begin
                  if (lbc_ff != 4'd0) begin
                     lshift_in = {lshift_ff[6:0], b};
                     lbc_in    = lbc_ff + 4'd1;
                     if (lbc_ff == 4'd8) begin
                        // leaf complete: store it and push it on the subtree stack
                        lbc_in   = 4'd0;
                        node_we  = 1'b1;
                        stk_we   = (depth_ff != 9'd0);
                        top_in   = free_ff;
                        depth_in = depth_ff + 9'd1;
                        free_in  = free_ff + 9'd1;
                        found_in = found_ff + 9'd1;
                        if (found_ff + 9'd1 == decl_ff && depth_ff == 9'd0) begin
                           emit_v   = 1'b1;
                           emit_bad = 1'b1;
                        end
                     end
                  end else if (b) begin
                     if (found_ff >= decl_ff) begin
                        emit_v   = 1'b1;
                        emit_bad = 1'b1;
                     end else begin
                        lbc_in    = 4'd1;
                        lshift_in = 8'd0;
                     end
                  end else begin
                     // join with fewer than two subtrees
                     emit_v   = 1'b1;
                     emit_bad = 1'b1;
                  end
               end
               default: ;
            endcase
            if (emit_bad) begin
               phase_in = PH_BAD;
            end
         end
         CMD_JOIN_RD: begin
            byte_in    = {byte_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 4'd1;
         end
         CMD_JOIN_DO: begin
            node_we    = 1'b1;
            node_wdata = {1'b0, stk_rdata, top_ff};
            top_in     = free_ff;
            depth_in   = depth_m1;
            free_in    = free_ff + 9'd1;
            if (found_ff == decl_ff && depth_m1 == 9'd1) begin
               phase_in = PH_WALK;
               root_in  = {1'b0, stk_rdata, top_ff};
               cur_in   = {1'b0, stk_rdata, top_ff};
            end
         end
         CMD_WALK_DO: begin
            // walk bit stays in place until the node read is used
            byte_in    = {byte_ff[6:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 4'd1;
            if (node_rdata[LEAF_BIT]) begin
               cur_in   = root_ff;
               left_in  = left_dec;
               emit_v   = 1'b1;
               emit_sym = node_rdata[7:0];
               emit_end = (left_dec == '0);
               if (left_dec == '0) begin
                  phase_in = PH_DONE;
               end
            end else begin
               cur_in = node_rdata;
            end
         end
         default: ;
      endcase
   end

   // pending result waits to learn whether it is the last of its request
   always_comb begin
      pend_v_in   = pend_v_ff;
      pend_sym_in = pend_sym_ff;
      pend_end_in = pend_end_ff;
      pend_bad_in = pend_bad_ff;
      out_v_in    = out_v_ff && !rsp_chan.ready;
      out_sym_in  = out_sym_ff;
      out_end_in  = out_end_ff;
      out_bad_in  = out_bad_ff;
      out_run_in  = out_run_ff;
      if (cmd == CMD_FLUSH) begin
         out_v_in    = 1'b1;
         out_sym_in  = pend_sym_ff;
         out_end_in  = pend_end_ff;
         out_bad_in  = pend_bad_ff;
         out_run_in  = 1'b1;
         pend_v_in   = 1'b0;
      end else if (emit_v) begin
         if (pend_v_ff) begin
            out_v_in   = 1'b1;
            out_sym_in = pend_sym_ff;
            out_end_in = pend_end_ff;
            out_bad_in = pend_bad_ff;
            out_run_in = 1'b0;
         end
         pend_v_in   = 1'b1;
         pend_sym_in = emit_sym;
         pend_end_in = emit_end;
         pend_bad_in = emit_bad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff <= 4'd8;
         phase_ff   <= PH_MARK;
         hdr_ff     <= '0;
         left_ff    <= '0;
         decl_ff    <= '0;
         found_ff   <= '0;
         lbc_ff     <= '0;
         free_ff    <= '0;
         depth_ff   <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         bit_cnt_ff <= bit_cnt_in;
         phase_ff   <= phase_in;
         hdr_ff     <= hdr_in;
         left_ff    <= left_in;
         decl_ff    <= decl_in;
         found_ff   <= found_in;
         lbc_ff     <= lbc_in;
         free_ff    <= free_in;
         depth_ff   <= depth_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
      byte_ff     <= byte_in;
      lshift_ff   <= lshift_in;
      top_ff      <= top_in;
      root_ff     <= root_in;
      cur_ff      <= cur_in;
      pend_sym_ff <= pend_sym_in;
      pend_end_ff <= pend_end_in;
      pend_bad_ff <= pend_bad_in;
      out_sym_ff  <= out_sym_in;
      out_end_ff  <= out_end_in;
      out_bad_ff  <= out_bad_in;
      out_run_ff  <= out_run_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.symbol      = out_sym_ff;
   assign rsp_chan.message_end = out_end_ff;
   assign rsp_chan.malformed   = out_bad_ff;
   assign rsp_chan.run_end     = out_run_ff;
endmodule

[src/huffman_stream_decoder_top.sv]
// channel  | dir | payload                                     | handshake
// req_chan | in  | data_byte[7:0], first_byte                  | valid/ready
// rsp_chan | out | symbol[7:0], message_end, malformed, run_end | valid/ready
// one request at a time: the request is accepted, each header or leaf bit is
// taken directly, each join or walk bit waits on a node or stack memory read,
// then the byte is seen used up and any last result is released.
// synchronous reset puts the decoder in the marker-bit phase.
// a stalled rsp holds the sequencer whenever a new result has nowhere to go.
// depends on hsd_pkg, hsd_if, hsd_ctrl, hsd_datapath
module huffman_stream_decoder_top
   import hsd_pkg::*;
#(
   parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   hsd_req_if.sink   req_chan,
   hsd_rsp_if.source rsp_chan
);
   dp_status_type status;
   cmd_type       cmd;

   hsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hsd_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_data_byte  (req_chan.data_byte),
      .req_first_byte (req_chan.first_byte),
      .cmd            (cmd),
      .status         (status),
      .rsp_chan       (rsp_chan)
   );
endmodule

[src/hsd_checker.sv]
// port level checks for the huffman stream decoder, bound to the top level
// depends on huffman_stream_decoder_top_assert.svh
`include "huffman_stream_decoder_top_assert.svh"
module hsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_symbol,
   input logic       rsp_message_end,
   input logic       rsp_malformed,
   input logic       rsp_run_end
);
   `HSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_symbol))
   `HSD_ASSERT_NOW(a_bad_clean, clock, reset, rsp_valid && rsp_malformed, rsp_symbol == 8'd0 && !rsp_message_end)
   `HSD_ASSERT_NOW(a_bad_last, clock, reset, rsp_valid && rsp_malformed, rsp_run_end)
   `HSD_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind huffman_stream_decoder_top hsd_checker u_hsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_symbol      (rsp_chan.symbol),
   .rsp_message_end (rsp_chan.message_end),
   .rsp_malformed   (rsp_chan.malformed),
   .rsp_run_end     (rsp_chan.run_end)
);

[verif/tb_huffman_stream_decoder_top.sv]
// testbench for huffman_stream_decoder_top: builds tree headers and coded streams,
// predicts decoded symbols with a scoreboard class and checks the response channel
// depends on hsd_pkg, hsd_if and huffman_stream_decoder_top
module tb_huffman_stream_decoder_top
   import hsd_pkg::*;
;

   typedef struct packed {
      logic [7:0] symbol;
      logic       message_end;
      logic       malformed;
      logic       run_end;
   } symbol_rec_type;

   class symbol_scoreboard;
      logic [18:0] node_mem[512];
      logic [8:0]  subtree_stk[256];
      phase_type   ph;
      int unsigned hdr_cnt, leaves_decl, leaves_got, shift_reg, leaf_cnt;
      int unsigned free_node, stk_top, root, walk;
      logic [31:0] remaining;
      symbol_rec_type pending_symbols[$];
      int          errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         ph = PH_MARK;
         hdr_cnt = 0; remaining = 0; leaves_decl = 0; leaves_got = 0;
         shift_reg = 0; leaf_cnt = 0; free_node = 0; stk_top = 0;
         root = 0; walk = 0;
      endfunction

      function bit push_node(logic [18:0] w);
         if (free_node >= 512 || stk_top >= 256) return 0;
         node_mem[free_node] = w;
         subtree_stk[stk_top] = free_node[8:0];
         free_node++;
         stk_top++;
         return 1;
      endfunction

      // -1 single-leaf tree, 0 still building, 1 done
      function int tree_done();
         if (leaves_got == leaves_decl && stk_top == 1) begin
            root = subtree_stk[0];
            if (node_mem[root][LEAF_BIT]) return -1;
            walk = root;
            ph = PH_WALK;
            return 1;
         end
         return 0;
      endfunction

      function void note_request(logic [7:0] data, logic first);
         symbol_rec_type r;
         int          n, first_idx;
         bit          bad, b;
         logic [18:0] w;
         int unsigned lft, rgt;
         n = 0;
         first_idx = pending_symbols.size();
         if (first) clear();
         for (int i = 7; i >= 0; i--) begin
            b = data[i];
            bad = 0;
            case (ph)
               PH_MARK: begin
                  ph = PH_COUNT;
                  hdr_cnt = 0;
               end
               PH_COUNT: begin
                  remaining = {remaining[30:0], b};
                  hdr_cnt++;
                  if (hdr_cnt >= 32) begin
                     hdr_cnt = 0;
                     leaves_decl = 0;
                     ph = (remaining == 0) ? PH_DONE : PH_LEAVES;
                  end
               end
               PH_LEAVES: begin
                  leaves_decl = ((leaves_decl << 1) | b) & 8'hff;
                  hdr_cnt++;
                  if (hdr_cnt >= 8) begin
                     hdr_cnt = 0;
                     if (leaves_decl == 0) leaves_decl = 256;
                     if (leaves_decl > 256) bad = 1;
                     else ph = PH_TREE;
                  end
               end
               PH_TREE: begin
                  if (leaf_cnt != 0) begin
                     shift_reg = ((shift_reg << 1) | b) & 8'hff;
                     leaf_cnt++;
                     if (leaf_cnt > 8) begin
                        leaf_cnt = 0;
                        if (!push_node({1'b1, 10'd0, shift_reg[7:0]})) bad = 1;
                        else begin
                           leaves_got++;
                           if (tree_done() < 0) bad = 1;
                        end
                     end
                  end else if (b) begin
                     if (leaves_got >= leaves_decl) bad = 1;
                     else begin
                        leaf_cnt = 1;
                        shift_reg = 0;
                     end
                  end else begin
                     if (stk_top < 2) bad = 1;
                     else begin
                        rgt = subtree_stk[stk_top - 1];
                        lft = subtree_stk[stk_top - 2];
                        stk_top -= 2;
                        if (!push_node({1'b0, lft[8:0], rgt[8:0]})) bad = 1;
                        else if (tree_done() < 0) bad = 1;
                     end
                  end
               end
               PH_WALK: begin
                  w = node_mem[walk];
                  walk = b ? w[8:0] : w[17:9];
                  w = node_mem[walk];
                  if (w[LEAF_BIT]) begin
                     walk = root;
                     remaining = remaining - 1;
                     r = '{w[7:0], remaining == 0, 1'b0, 1'b0};
                     pending_symbols.push_back(r);
                     n++;
                     if (remaining == 0) ph = PH_DONE;
                  end
               end
               default: ;
            endcase
            if (bad) begin
               pending_symbols.push_back('{8'd0, 1'b0, 1'b1, 1'b0});
               n++;
               ph = PH_BAD;
               break;
            end
         end
         if (n > 0) pending_symbols[first_idx + n - 1].run_end = 1'b1;
      endfunction

      function void check_result(symbol_rec_type got);
         symbol_rec_type exp_rec;
         if (pending_symbols.size() == 0) begin
            $display("%0t: unexpected result: actual %h", $realtime, got);
            errors++;
            return;
         end
         exp_rec = pending_symbols.pop_front();
         if (got !== exp_rec) begin
            $display("%0t: mismatch: expected sym=%h end=%b bad=%b last=%b,",
                     $realtime, exp_rec.symbol, exp_rec.message_end, exp_rec.malformed,
                     exp_rec.run_end,
                     " actual sym=%h end=%b bad=%b last=%b",
                     got.symbol, got.message_end, got.malformed, got.run_end);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   hsd_req_if req_chan ();
   hsd_rsp_if rsp_chan ();
   symbol_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   bit          stim_done = 0;
   localparam int unsigned CYCLE_LIMIT = 400000;

   huffman_stream_decoder_top dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // request acceptance feeds the predictor, response acceptance is checked
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_request(req_chan.data_byte, req_chan.first_byte);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_result('{rsp_chan.symbol, rsp_chan.message_end, rsp_chan.malformed,
                           rsp_chan.run_end});
   end

   // response side stalls at random, with calm stretches
   initial begin
      int unsigned stall;
      rsp_chan.ready = 0;
      @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (($urandom_range(0, 7) == 0) || stim_done) stall = 0;
         if (stall != 0) begin
            rsp_chan.ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   bit          bitbuf[$];
   int          gap_mode;

   task automatic send_request(logic [7:0] data, logic first);
      int unsigned gap;
      gap = (gap_mode == 0) ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.data_byte <= data;
      req_chan.first_byte <= first;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
      if ($urandom_range(0, 20) == 0) gap_mode = 1 - gap_mode;
   endtask

   task automatic drain_wait();
      int unsigned guard;
      req_chan.valid <= 0;
      guard = 0;
      while (sb.pending_symbols.size() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (30) @(negedge clock);
   endtask

   task automatic put_bits(int unsigned v, int nbits);
      for (int i = nbits - 1; i >= 0; i--) bitbuf.push_back(bit'((v >> i) & 1));
   endtask

   // packs bitbuf into bytes, pad random, first byte marked
   task automatic send_bits(bit mark_first);
      logic [7:0] b;
      bit first;
      first = mark_first;
      while (bitbuf.size() % 8 != 0) bitbuf.push_back(bit'($urandom_range(0, 1)));
      while (bitbuf.size() != 0) begin
         for (int i = 7; i >= 0; i--) b[i] = bitbuf.pop_front();
         send_request(b, first);
         first = 0;
      end
   endtask

   // balanced-ish random tree of nleaves leaves; codes returned per leaf
   int unsigned leaf_sym[256];
   int unsigned leaf_code[256];
   int unsigned leaf_len[256];

   task automatic build_tree(int nleaves);
      int unsigned stk_first[$], stk_cnt[$];
      int unsigned f, c, f2, c2;
      int made;
      made = 0;
      for (int i = 0; i < nleaves; i++) begin
         leaf_sym[i] = $urandom_range(0, 255);
         leaf_code[i] = 0;
         leaf_len[i] = 0;
      end
      while (made < nleaves || stk_first.size() > 1) begin
         if (made < nleaves && (stk_first.size() < 2 || $urandom_range(0, 1))) begin
            put_bits(1, 1);
            put_bits(leaf_sym[made], 8);
            stk_first.push_back(made);
            stk_cnt.push_back(1);
            made++;
         end else begin
            put_bits(0, 1);
            f2 = stk_first.pop_back(); c2 = stk_cnt.pop_back();
            f = stk_first.pop_back(); c = stk_cnt.pop_back();
            for (int k = 0; k < c; k++) leaf_len[f + k]++;
            for (int k = 0; k < c2; k++) begin
               leaf_code[f2 + k] |= 1 << leaf_len[f2 + k];
               leaf_len[f2 + k]++;
            end
            stk_first.push_back(f);
            stk_cnt.push_back(c + c2);
         end
      end
   endtask

   // codes were built leaf-up, so bit k counted from the root is at len-1-k
   task automatic send_message(int unsigned count, int nleaves, int nsyms);
      int unsigned j;
      bitbuf.delete();
      put_bits($urandom_range(0, 1), 1);
      put_bits(count, 32);
      put_bits(nleaves & 8'hff, 8);
      if (count != 0) begin
         build_tree(nleaves);
         for (int s = 0; s < nsyms; s++) begin
            j = $urandom_range(0, nleaves - 1);
            for (int k = leaf_len[j] - 1; k >= 0; k--)
               bitbuf.push_back(bit'((leaf_code[j] >> k) & 1));
         end
      end
      send_bits(1);
   endtask

   task automatic send_broken();
      bitbuf.delete();
      put_bits(0, 1);
      put_bits($urandom_range(1, 20), 32);
      case ($urandom_range(0, 2))
         0: begin put_bits(4, 8); put_bits(0, 1); end
         1: begin put_bits(1, 8); put_bits(1, 1); put_bits($urandom_range(0, 255), 8); end
         default: begin
            put_bits(1, 8);
            put_bits(1, 1); put_bits(7, 8);
            put_bits(1, 1); put_bits(9, 8);
         end
      endcase
      send_bits(1);
   endtask

   initial begin
      int unsigned cnt, nl;
      req_chan.valid = 0;
      req_chan.data_byte = 0;
      req_chan.first_byte = 0;
      gap_mode = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: zero count, two leaves, leaf count 0 read as 256, malformed headers
      send_message(0, 2, 0);
      send_message(3, 2, 3);
      send_request(8'hff, 0);
      // with 256 leaves declared, two leaves and two joins fail only at the second join
      bitbuf.delete();
      put_bits(0, 1);
      put_bits(5, 32);
      put_bits(0, 8);
      put_bits(1, 1); put_bits(3, 8);
      put_bits(1, 1); put_bits(4, 8);
      put_bits(0, 1); put_bits(0, 1);
      send_bits(1);
      send_broken();
      send_request(8'h00, 0);
      send_message(32'hffffffff, 3, 6);
      drain_wait();

      while (requests_sent < 280) begin
         if ($urandom_range(0, 9) == 0) send_broken();
         else if ($urandom_range(0, 14) == 0)
            send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         else begin
            nl = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 8);
            cnt = $urandom_range(1, 20);
            send_message(($urandom_range(0, 5) == 0) ? cnt + 5 : cnt, nl, cnt);
         end
         if ($urandom_range(0, 15) == 0) drain_wait();
      end
      stim_done = 1;
      drain_wait();
      if (sb.errors == 0 && sb.pending_symbols.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (sb.pending_symbols.size() != 0)
            $display("%0t: %0d expected results never arrived", $realtime,
                     sb.pending_symbols.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

[huffman_stream_decoder_top.f]
+incdir+src
src/hsd_pkg.sv
src/hsd_if.sv
src/hsd_ram.sv
src/hsd_ctrl.sv
src/hsd_datapath.sv
src/huffman_stream_decoder_top.sv
src/hsd_checker.sv
verif/tb_huffman_stream_decoder_top.sv
